// ----- hdl/czi_pkg.sv -----
// czi_pkg: zone codes, register indexes, colour constants and the result record
// shared by the collision zone interlock; no dependencies
`timescale 1ns / 1ps

package czi_pkg;

    localparam int DIST_W  = 12;
    localparam int MODE_W  = 2;
    localparam int TIME_W  = 32;
    localparam int SPEED_W = 9;
    localparam int THR_W   = 11;
    localparam int PER_W   = 16;
    localparam int RED_W   = 6;
    localparam int GREEN_W = 5;
    localparam int ZONE_W  = 2;

    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 64;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [ZONE_W-1:0] ZONE_CLEAR = 2'd0;
    localparam logic [ZONE_W-1:0] ZONE_WARN  = 2'd1;
    localparam logic [ZONE_W-1:0] ZONE_CRIT  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_AUTO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEMI = 2'd1;

    localparam logic [CFG_ADDR_W-1:0] REG_STOP_DIST  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOW_DIST  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WARN_BEEP  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CRIT_BEEP  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BLINK      = 3'd5;

    localparam logic [THR_W-1:0] STOP_DIST_RST = 11'd15;
    localparam logic [THR_W-1:0] SLOW_DIST_RST = 11'd40;
    localparam logic [PER_W-1:0] DEBOUNCE_RST  = 16'd500;
    localparam logic [PER_W-1:0] WARN_BEEP_RST = 16'd500;
    localparam logic [PER_W-1:0] CRIT_BEEP_RST = 16'd150;
    localparam logic [PER_W-1:0] BLINK_RST     = 16'd200;

    localparam logic [RED_W-1:0]   RED_BRIGHT = 6'd40;
    localparam logic [RED_W-1:0]   RED_WARN   = 6'd30;
    localparam logic [RED_W-1:0]   RED_DIM    = 6'd5;
    localparam logic [GREEN_W-1:0] GREEN_ON   = 5'd20;

    localparam logic TONE_WARN = 1'b0;
    localparam logic TONE_CRIT = 1'b1;

    // packed from the highest field down so that zone lands in bit 0
    typedef struct packed {
        logic [TIME_W-1:0]         since_collision_ms;
        logic signed [SPEED_W-1:0] limited_speed;
        logic                      buzzer_stop;
        logic                      tone_kind;
        logic                      tone_start;
        logic [GREEN_W-1:0]        led_green;
        logic [RED_W-1:0]          led_red;
        logic                      led_write;
        logic                      motor_stop;
        logic                      override_on;
        logic [ZONE_W-1:0]         zone;
    } czi_result_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] requested_speed;
        logic [TIME_W-1:0]         now_ms;
        logic [MODE_W-1:0]         drive_mode;
        logic signed [DIST_W-1:0]  distance_cm;
    } czi_sample_t;

endpackage

// ----- hdl/collision_zone_interlock.sv -----
// collision_zone_interlock: zone classification, stop lock with debounce, LED,
// buzzer and speed limiting for one distance sample per request; uses czi_pkg
`timescale 1ns / 1ps

// One request is taken per clock while the output register is empty or being read:
// the sample lands in an input register, all compares, wrapping time subtractions
// and the speed halving run in one stage of logic, and the result is held in an
// output register while the next sample is already taken. State (lock, debounce
// start, tone, blink and stop times) is updated as each sample moves into the
// output register, so back-to-back samples see each other. tdata in:
// distance_cm[11:0], drive_mode[13:12], now_ms[45:14], requested_speed[54:46].
// tdata out: see the port list. The user must write registers through
// cfg_we/cfg_addr/cfg_wdata only while the block is idle; the block does not enforce it.
module collision_zone_interlock (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [czi_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [czi_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // distance_cm[11:0], drive_mode[13:12], now_ms[45:14], requested_speed[54:46]
    input  logic [czi_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // zone[1:0], override_on[2], motor_stop[3], led_write[4], led_red[10:5],
    // led_green[15:11], tone_start[16], tone_kind[17], buzzer_stop[18],
    // limited_speed[27:19], since_collision_ms[59:28], zero fill [63:60]
    output logic [czi_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import czi_pkg::*;

    localparam int RES_W = $bits(czi_result_t);
    localparam int SMP_W = $bits(czi_sample_t);

    // configuration
    logic [THR_W-1:0] stop_dist_reg, slow_dist_reg;
    logic [PER_W-1:0] debounce_reg, warn_beep_reg, crit_beep_reg, blink_reg;

    // block state
    logic              lock_reg, lock_next;
    logic              wait_reg, wait_next;
    logic [TIME_W-1:0] safe_start_reg, safe_start_next;
    logic [TIME_W-1:0] last_stop_reg, last_stop_next;
    logic              stop_seen_reg, stop_seen_next;
    logic [TIME_W-1:0] last_tone_reg, last_tone_next;
    logic              buzz_reg, buzz_next;
    logic [ZONE_W-1:0] led_zone_reg, led_zone_next;
    logic [TIME_W-1:0] last_blink_reg, last_blink_next;
    logic              bright_reg, bright_next;

    // pipeline
    logic        in_valid_reg;
    czi_sample_t in_data_reg;
    logic        out_valid_reg;
    czi_result_t out_data_reg;
    czi_result_t res_next;
    logic        adv;

    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - RES_W){1'b0}}, out_data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_dist_reg <= STOP_DIST_RST;
            slow_dist_reg <= SLOW_DIST_RST;
            debounce_reg  <= DEBOUNCE_RST;
            warn_beep_reg <= WARN_BEEP_RST;
            crit_beep_reg <= CRIT_BEEP_RST;
            blink_reg     <= BLINK_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_STOP_DIST: stop_dist_reg <= cfg_wdata[THR_W-1:0];
                REG_SLOW_DIST: slow_dist_reg <= cfg_wdata[THR_W-1:0];
                REG_DEBOUNCE:  debounce_reg  <= cfg_wdata[PER_W-1:0];
                REG_WARN_BEEP: warn_beep_reg <= cfg_wdata[PER_W-1:0];
                REG_CRIT_BEEP: crit_beep_reg <= cfg_wdata[PER_W-1:0];
                REG_BLINK:     blink_reg     <= cfg_wdata[PER_W-1:0];
                default: ;
            endcase
        end
    end

    // per-sample logic
    logic [ZONE_W-1:0]     zone_raw, zone_q;
    logic [DIST_W-2:0]     dist_mag;
    logic [TIME_W-1:0]     start_eff, now_ms;
    logic [PER_W-1:0]      beep_per;
    logic                  ovr;
    logic signed [SPEED_W:0] half_sum;

    always_comb begin
        now_ms          = in_data_reg.now_ms;
        dist_mag        = in_data_reg.distance_cm[DIST_W-2:0];
        lock_next       = lock_reg;
        wait_next       = wait_reg;
        safe_start_next = safe_start_reg;
        last_stop_next  = last_stop_reg;
        stop_seen_next  = stop_seen_reg;
        last_tone_next  = last_tone_reg;
        buzz_next       = buzz_reg;
        led_zone_next   = led_zone_reg;
        last_blink_next = last_blink_reg;
        bright_next     = bright_reg;
        res_next        = '0;
        zone_q          = ZONE_CLEAR;
        ovr             = 1'b0;
        start_eff       = wait_reg ? safe_start_reg : now_ms;
        beep_per        = crit_beep_reg;

        if ({1'b0, dist_mag} <= {1'b0, stop_dist_reg}) begin
            zone_raw = ZONE_CRIT;
        end else if ({1'b0, dist_mag} <= {1'b0, slow_dist_reg}) begin
            zone_raw = ZONE_WARN;
        end else begin
            zone_raw = ZONE_CLEAR;
        end

        // negative distance means no data: report safe, touch nothing else
        if (!in_data_reg.distance_cm[DIST_W-1]) begin
            zone_q = zone_raw;
            if (lock_reg && zone_raw != ZONE_CRIT) begin
                wait_next       = 1'b1;
                safe_start_next = start_eff;
                if ((now_ms - start_eff) < {{(TIME_W-PER_W){1'b0}}, debounce_reg}) begin
                    zone_q = ZONE_CRIT;
                end else begin
                    lock_next = 1'b0;
                    wait_next = 1'b0;
                end
            end

            case (in_data_reg.drive_mode)
                MODE_AUTO: ovr = (zone_q != ZONE_CLEAR);
                MODE_SEMI: ovr = (zone_q == ZONE_CRIT);
                default:   ovr = 1'b0;
            endcase

            if (ovr && zone_q == ZONE_CRIT) begin
                res_next.motor_stop = 1'b1;
                lock_next           = 1'b1;
                last_stop_next      = now_ms;
                stop_seen_next      = 1'b1;
            end

            case (zone_q)
                ZONE_CLEAR: begin
                    if (led_zone_reg != ZONE_CLEAR) begin
                        res_next.led_write = 1'b1;
                        res_next.led_green = GREEN_ON;
                    end
                end
                ZONE_WARN: begin
                    if (led_zone_reg != ZONE_WARN) begin
                        res_next.led_write = 1'b1;
                        res_next.led_red   = RED_WARN;
                        res_next.led_green = GREEN_ON;
                    end
                end
                default: begin
                    if ((now_ms - last_blink_reg) >= {{(TIME_W-PER_W){1'b0}}, blink_reg}) begin
                        bright_next        = !bright_reg;
                        res_next.led_write = 1'b1;
                        res_next.led_red   = bright_reg ? RED_DIM : RED_BRIGHT;
                        last_blink_next    = now_ms;
                    end
                end
            endcase
            led_zone_next = zone_q;

            if (zone_q == ZONE_CLEAR) begin
                if (buzz_reg) begin
                    res_next.buzzer_stop = 1'b1;
                    buzz_next            = 1'b0;
                end
            end else begin
                beep_per = (zone_q == ZONE_WARN) ? warn_beep_reg : crit_beep_reg;
                if ((now_ms - last_tone_reg) >= {{(TIME_W-PER_W){1'b0}}, beep_per}) begin
                    res_next.tone_start = 1'b1;
                    res_next.tone_kind  = (zone_q == ZONE_WARN) ? TONE_WARN : TONE_CRIT;
                    last_tone_next      = now_ms;
                    buzz_next           = 1'b1;
                end
            end
        end

        // halve toward zero: bias negatives by one before the shift
        half_sum = {in_data_reg.requested_speed[SPEED_W-1], in_data_reg.requested_speed}
                 + {{SPEED_W{1'b0}}, in_data_reg.requested_speed[SPEED_W-1]};

        res_next.zone        = zone_q;
        res_next.override_on = ovr;
        case (zone_q)
            ZONE_WARN: res_next.limited_speed = half_sum[SPEED_W:1];
            ZONE_CRIT: res_next.limited_speed = '0;
            default:   res_next.limited_speed = in_data_reg.requested_speed;
        endcase
        res_next.since_collision_ms = stop_seen_next ? (now_ms - last_stop_next) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            lock_reg       <= 1'b0;
            wait_reg       <= 1'b0;
            safe_start_reg <= '0;
            last_stop_reg  <= '0;
            stop_seen_reg  <= 1'b0;
            last_tone_reg  <= '0;
            buzz_reg       <= 1'b0;
            led_zone_reg   <= ZONE_CLEAR;
            last_blink_reg <= '0;
            bright_reg     <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (adv) begin
                out_valid_reg  <= 1'b1;
                lock_reg       <= lock_next;
                wait_reg       <= wait_next;
                safe_start_reg <= safe_start_next;
                last_stop_reg  <= last_stop_next;
                stop_seen_reg  <= stop_seen_next;
                last_tone_reg  <= last_tone_next;
                buzz_reg       <= buzz_next;
                led_zone_reg   <= led_zone_next;
                last_blink_reg <= last_blink_next;
                bright_reg     <= bright_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_data_reg <= czi_sample_t'(s_axis_tdata[SMP_W-1:0]);
        end
        if (adv) begin
            out_data_reg <= res_next;
        end
    end

    // a stop request must leave the lock set
    a_stop_locks: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && res_next.motor_stop |=> lock_reg)
        else $error("lock not set after motor stop");

    // a started tone marks the buzzer as sounding
    a_tone_buzz: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && res_next.tone_start |=> buzz_reg)
        else $error("buzzer flag not set after tone start");

    // an empty output stage never blocks the input side
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    // a moved sample always shows up as a result
    a_adv_out: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> m_axis_tvalid)
        else $error("result lost after advance");

    // the lock holds critical while debouncing
    a_wait_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        wait_reg |-> lock_reg)
        else $error("debounce waiting without lock");

endmodule
